>>> hdl/fnv_keystream_xor_cipher_macros.svh
// Assertion macros for the keystream cipher checker.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef FNV_KEYSTREAM_XOR_CIPHER_MACROS_SVH
`define FNV_KEYSTREAM_XOR_CIPHER_MACROS_SVH

// Same-cycle implication.
`define FKX_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FKX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/fkx_pkg.sv
// ----------------------------------------------------------------------------
// fkx_pkg
// Constants and helper functions for the FNV keystream xor cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package fkx_pkg;

	localparam int unsigned POS_W      = 16;
	localparam int unsigned IDX_BYTES  = 8;
	localparam int unsigned SALT_LEN   = 25;
	localparam int unsigned SEED_STEPS = IDX_BYTES + SALT_LEN;
	localparam int unsigned STEP_W     = $clog2(SEED_STEPS);
	localparam int unsigned SALT_W     = $clog2(SALT_LEN);

	localparam logic [POS_W-1:0] MAX_BYTES = 16'd65535;
	localparam logic [63:0]      FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

	// Multiply by 0x0000_0100_0000_01B3 modulo 2^64 as a shift-add.
	function automatic logic [63:0] mul_prime(input logic [63:0] x);
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	// Salt characters, first character at index zero.
	function automatic logic [7:0] salt_char(input logic [SALT_W-1:0] k);
		logic [7:0] c;
		case (k)
			5'd0:    c = 8'h43;
			5'd1:    c = 8'h43;
			5'd2:    c = 8'h43;
			5'd3:    c = 8'h61;
			5'd4:    c = 8'h73;
			5'd5:    c = 8'h74;
			5'd6:    c = 8'h65;
			5'd7:    c = 8'h72;
			5'd8:    c = 8'h5F;
			5'd9:    c = 8'h76;
			5'd10:   c = 8'h31;
			5'd11:   c = 8'h30;
			5'd12:   c = 8'h5F;
			5'd13:   c = 8'h53;
			5'd14:   c = 8'h65;
			5'd15:   c = 8'h73;
			5'd16:   c = 8'h73;
			5'd17:   c = 8'h69;
			5'd18:   c = 8'h6F;
			5'd19:   c = 8'h6E;
			5'd20:   c = 8'h5F;
			5'd21:   c = 8'h32;
			5'd22:   c = 8'h30;
			5'd23:   c = 8'h32;
			5'd24:   c = 8'h36;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/fkx_if.sv
// ----------------------------------------------------------------------------
// fkx_if
// Valid/ready channel interfaces for the cipher data and configuration paths.
// ----------------------------------------------------------------------------
`default_nettype none

interface fkx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fkx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;
	logic       overflow;

	modport source (output valid, output out_byte, output last_out, output overflow,
		input ready);
	modport sink   (input valid, input out_byte, input last_out, input overflow,
		output ready);
endinterface

interface fkx_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] window_index;

	modport source (output valid, output window_index, input ready);
	modport sink   (input valid, input window_index, output ready);
endinterface

`default_nettype wire

>>> hdl/fkx_seed.sv
// ----------------------------------------------------------------------------
// fkx_seed
// Seed derivation: folds eight index bytes and the salt, one fold per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fkx_seed (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] window_index,
	output logic             busy,
	output logic [63:0]      seed
);

	logic                            busy_q;
	logic [fkx_pkg::STEP_W-1:0]      step_q;
	logic [63:0]                     hash_q;
	logic [63:0]                     idx_q;
	logic [63:0]                     seed_q;
	logic [7:0]                      fold_byte;
	logic [fkx_pkg::SALT_W-1:0]      salt_sel;
	logic [63:0]                     hash_next;
	logic                            last_step;

	assign salt_sel  = fkx_pkg::SALT_W'(step_q - fkx_pkg::STEP_W'(fkx_pkg::IDX_BYTES));
	assign fold_byte = (step_q < fkx_pkg::STEP_W'(fkx_pkg::IDX_BYTES)) ? idx_q[7:0]
		: fkx_pkg::salt_char(salt_sel);
	assign hash_next = fkx_pkg::mul_prime(hash_q ^ {56'd0, fold_byte});
	assign last_step = (step_q == fkx_pkg::STEP_W'(fkx_pkg::SEED_STEPS - 1));

	// Reset starts a derivation for window index zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= '0;
			hash_q <= fkx_pkg::FNV_BASIS;
			idx_q  <= '0;
			seed_q <= '0;
		end else if (busy_q) begin
			hash_q <= hash_next;
			idx_q  <= idx_q >> 8;
			step_q <= step_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
				seed_q <= hash_next;
			end
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			hash_q <= fkx_pkg::FNV_BASIS;
			idx_q  <= window_index;
		end
	end

	assign busy = busy_q;
	assign seed = seed_q;

endmodule

`default_nettype wire

>>> hdl/fnv_keystream_xor_cipher.sv
// ----------------------------------------------------------------------------
// fnv_keystream_xor_cipher
// Byte stream cipher: xors each byte with a keystream byte from an FNV chain.
// ----------------------------------------------------------------------------
//  channel  dir  transaction payload
//  in_ch    in   data_byte[7:0], last_byte
//  out_ch   out  out_byte[7:0], last_out, overflow
//  cfg_ch   in   window_index[63:0]
//
//  One byte per cycle while out_ch is ready and no seed derivation runs.
//  The chain update (xor, shift-add multiply) is the single per-byte loop.
//  Each byte passes the s1 and s2 registers. A window index write runs the
//  seed folding, with in_ch and cfg_ch ready low; reset starts it too.
//  A stalled out_ch holds its result; in_ch keeps taking one more byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_keystream_xor_cipher (
	input  wire logic clk,
	input  wire logic arst_n,
	fkx_in_if.sink    in_ch,
	fkx_out_if.source out_ch,
	fkx_cfg_if.sink   cfg_ch
);

	logic                       seed_busy;
	logic [63:0]                seed;

	logic                       valid_s1;
	logic [7:0]                 data_s1;
	logic                       last_s1;

	logic                       valid_s2;
	logic [7:0]                 out_byte_s2;
	logic                       last_s2;
	logic                       ovf_s2;

	logic [63:0]                chain_q;
	logic [fkx_pkg::POS_W-1:0]  pos_q;

	logic                       adv_s1;
	logic                       ovf;
	logic [fkx_pkg::POS_W:0]    term;
	logic [63:0]                chain_base;
	logic [63:0]                chain_new;

	fkx_seed u_seed (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (cfg_ch.valid),
		.window_index (cfg_ch.window_index),
		.busy         (seed_busy),
		.seed         (seed)
	);

	assign cfg_ch.ready = !seed_busy;

	assign adv_s1      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !seed_busy && (!valid_s1 || adv_s1);

	assign ovf        = (pos_q >= fkx_pkg::MAX_BYTES);
	assign term       = {1'b0, pos_q} + 1'b1;
	assign chain_base = (pos_q == '0) ? seed : chain_q;
	assign chain_new  = fkx_pkg::mul_prime(chain_base ^ 64'(term));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// Advance the chain and the byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			pos_q   <= '0;
		end else if (adv_s1) begin
			chain_q <= chain_new;
			if (last_s1) begin
				pos_q <= '0;
			end else if (!ovf) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_byte_s2 <= data_s1 ^ chain_new[31:24];
			last_s2     <= last_s1;
			ovf_s2      <= ovf;
		end
	end

	assign out_ch.valid    = valid_s2;
	assign out_ch.out_byte = out_byte_s2;
	assign out_ch.last_out = last_s2;
	assign out_ch.overflow = ovf_s2;

endmodule

`default_nettype wire

>>> hdl/fkx_checker.sv
// ----------------------------------------------------------------------------
// fkx_checker
// Port-level assertions for the keystream cipher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fnv_keystream_xor_cipher_macros.svh"

module fkx_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_byte,
	input  wire logic       last_out,
	input  wire logic       overflow,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready
);

	logic       out_stall;
	logic       in_take;
	logic       cfg_take;
	logic [9:0] out_pay;

	assign out_stall = out_valid && !out_ready;
	assign in_take   = in_valid && in_ready;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign out_pay   = {out_byte, last_out, overflow};

	`FKX_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_pay), "result changed in stall")
	`FKX_ASSERT_IMPLY(a_in_needs_seed, in_ready, cfg_ready, "input open during seed derivation")
	`FKX_ASSERT_NEXT(a_cfg_blocks, cfg_take, !in_ready && !cfg_ready, "open after index write")
	`FKX_ASSERT_IMPLY(a_out_has_source, $rose(out_valid), $past(in_take, 2), "result without input")

endmodule

bind fnv_keystream_xor_cipher fkx_checker u_fkx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.last_out  (out_ch.last_out),
	.overflow  (out_ch.overflow),
	.cfg_valid (cfg_ch.valid),
	.cfg_ready (cfg_ch.ready)
);

`default_nettype wire
